@@ hdl/aes_round_transform_defines.svh @@
// ---------------------------------------------------------------------------
// aes_round_transform_defines.svh
// Assertion macros for the AES round transform RTL.
// ---------------------------------------------------------------------------
`ifndef AES_ROUND_TRANSFORM_DEFINES_SVH
`define AES_ROUND_TRANSFORM_DEFINES_SVH

`ifndef SYNTHESIS

// Clocked check, disabled while reset is asserted
`define AES_RT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds while reset is asserted
`define AES_RT_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define AES_RT_ASSERT(lbl, prop, msg)
`define AES_RT_ASSERT_RST(lbl, prop, msg)

`endif

`endif

@@ hdl/aes_rt_pkg.sv @@
// ---------------------------------------------------------------------------
// aes_rt_pkg
// Types, constants and byte functions for the AES round transform.
// ---------------------------------------------------------------------------
package aes_rt_pkg;

	localparam int BLOCK_W   = 128;
	localparam int NUM_ROWS  = 4;
	localparam int NUM_COLS  = 4;
	localparam logic [7:0] XTIME_POLY = 8'h1B;

	typedef logic [7:0] byte_t;
	// one state column, element r is row r
	typedef byte_t [NUM_ROWS-1:0] col_t;
	typedef col_t [NUM_COLS-1:0] cols_t;

	typedef struct packed {
		logic load_s1;
		logic load_s2;
	} ctrl_t;

	localparam byte_t SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
		8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
		8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
		8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
		8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
		8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
		8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
		8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
		8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
		8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
		8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
		8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
		8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
		8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
		8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
		8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
		8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic byte_t sbox(input byte_t b);
		return SBOX[b];
	endfunction

	function automatic byte_t xtime(input byte_t b);
		return {b[6:0], 1'b0} ^ (b[7] ? XTIME_POLY : 8'h00);
	endfunction

endpackage

@@ hdl/aes_rt_in_if.sv @@
// ---------------------------------------------------------------------------
// aes_rt_in_if
// Input channel: state block and round key with valid/ready handshake.
// ---------------------------------------------------------------------------
interface aes_rt_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] block_hi;
	logic [63:0] block_lo;
	logic [63:0] round_key_hi;
	logic [63:0] round_key_lo;

	modport source (
		output valid, block_hi, block_lo, round_key_hi, round_key_lo,
		input  ready
	);

	modport sink (
		input  valid, block_hi, block_lo, round_key_hi, round_key_lo,
		output ready
	);
endinterface

@@ hdl/aes_rt_out_if.sv @@
// ---------------------------------------------------------------------------
// aes_rt_out_if
// Result channel: round output with valid/ready handshake.
// ---------------------------------------------------------------------------
interface aes_rt_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] out_hi;
	logic [63:0] out_lo;

	modport source (
		output valid, out_hi, out_lo,
		input  ready
	);

	modport sink (
		input  valid, out_hi, out_lo,
		output ready
	);
endinterface

@@ hdl/aes_round_transform.sv @@
// ---------------------------------------------------------------------------
// aes_round_transform
// One AES encryption round: SubBytes, ShiftRows, MixColumns, AddRoundKey.
// ---------------------------------------------------------------------------
//  channel  | modport | payload
//  ---------+---------+----------------------------------------------------
//  block    | sink    | block_hi, block_lo, round_key_hi, round_key_lo
//  result   | source  | out_hi, out_lo
//
//  One transaction per cycle while the result channel is ready, set by the four
//  column lanes working in parallel (S-box register, then output register).
//  Reset clears only the two stage valid bits.
//  A stalled result holds in the output register; stage 1 still takes a new
//  block while the output slot is full, so ready drops only with both full.
// ---------------------------------------------------------------------------
module aes_round_transform import aes_rt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	aes_rt_in_if.sink    block,
	aes_rt_out_if.source result
);

	logic [BLOCK_W-1:0] state_vec;
	logic [BLOCK_W-1:0] key_vec;
	ctrl_t              ctrl;
	cols_t              lane_col;

	assign state_vec = {block.block_hi, block.block_lo};
	assign key_vec   = {block.round_key_hi, block.round_key_lo};

	for (genvar c = 0; c < NUM_COLS; c++) begin : g_lane
		col_t col_in;
		col_t key_in;

		// ShiftRows: row r takes the byte r columns to the right
		for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
			assign col_in[r] =
				state_vec[BLOCK_W-1-8*(NUM_COLS*r+((c+r)%NUM_COLS)) -: 8];
			assign key_in[r] = key_vec[BLOCK_W-1-8*(NUM_COLS*r+c) -: 8];
		end

		aes_rt_lane u_lane (
			.clk     (clk),
			.ctrl    (ctrl),
			.col_in  (col_in),
			.key_in  (key_in),
			.col_out (lane_col[c])
		);
	end

	aes_rt_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (block.valid),
		.in_ready (block.ready),
		.ctrl     (ctrl),
		.lane_col (lane_col),
		.result   (result)
	);

endmodule

@@ hdl/aes_rt_lane.sv @@
// ---------------------------------------------------------------------------
// aes_rt_lane
// One column lane: S-box on the shifted column, then MixColumns and key add.
// ---------------------------------------------------------------------------
module aes_rt_lane import aes_rt_pkg::*; (
	input  logic  clk,
	input  ctrl_t ctrl,
	input  col_t  col_in,
	input  col_t  key_in,
	output col_t  col_out
);

	col_t sub_s1;
	col_t key_s1;
	col_t dbl;

	always_ff @(posedge clk) begin
		if (ctrl.load_s1) begin
			for (int r = 0; r < NUM_ROWS; r++) begin
				sub_s1[r] <= sbox(col_in[r]);
			end
			key_s1 <= key_in;
		end
	end

	always_comb begin
		for (int r = 0; r < NUM_ROWS; r++) begin
			dbl[r] = xtime(sub_s1[r]);
		end
		col_out[0] = dbl[0] ^ dbl[1] ^ sub_s1[1] ^ sub_s1[2] ^ sub_s1[3] ^ key_s1[0];
		col_out[1] = sub_s1[0] ^ dbl[1] ^ dbl[2] ^ sub_s1[2] ^ sub_s1[3] ^ key_s1[1];
		col_out[2] = sub_s1[0] ^ sub_s1[1] ^ dbl[2] ^ dbl[3] ^ sub_s1[3] ^ key_s1[2];
		col_out[3] = dbl[0] ^ sub_s1[0] ^ sub_s1[1] ^ sub_s1[2] ^ dbl[3] ^ key_s1[3];
	end

endmodule

@@ hdl/aes_rt_merge.sv @@
// ---------------------------------------------------------------------------
// aes_rt_merge
// Pipeline control and output register; gathers lane columns into the block.
// ---------------------------------------------------------------------------
`include "aes_round_transform_defines.svh"

module aes_rt_merge import aes_rt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output ctrl_t ctrl,
	input  cols_t lane_col,
	aes_rt_out_if.source result
);

	logic                 valid_s1;
	logic                 valid_s2;
	logic [BLOCK_W-1:0]   merged;
	logic [BLOCK_W-1:0]   data_s2;

	// output slot frees when empty or when its transaction completes
	assign ctrl.load_s2 = !valid_s2 || result.ready;
	assign ctrl.load_s1 = !valid_s1 || ctrl.load_s2;
	assign in_ready     = ctrl.load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ctrl.load_s1) begin
				valid_s1 <= in_valid;
			end
			if (ctrl.load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// byte 4*row+col sits at the top of the block for index 0
	always_comb begin
		merged = '0;
		for (int c = 0; c < NUM_COLS; c++) begin
			for (int r = 0; r < NUM_ROWS; r++) begin
				merged[BLOCK_W-1-8*(NUM_COLS*r+c) -: 8] = lane_col[c][r];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_s2) begin
			data_s2 <= merged;
		end
	end

	assign result.valid  = valid_s2;
	assign result.out_hi = data_s2[BLOCK_W-1 -: 64];
	assign result.out_lo = data_s2[63:0];

	`AES_RT_ASSERT(a_accept_fills_s1, in_valid && in_ready |=> valid_s1, "accepted transaction lost before stage 1")
	`AES_RT_ASSERT(a_s1_moves_to_s2, valid_s1 && ctrl.load_s2 |=> valid_s2, "stage 1 item dropped on transfer")
	`AES_RT_ASSERT(a_s1_holds_on_stall, valid_s1 && !ctrl.load_s2 |=> valid_s1, "stalled stage 1 item lost")
	`AES_RT_ASSERT_RST(a_reset_no_result, !arst_n |=> !valid_s2 && !valid_s1, "valid set during reset")

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Checks the AES round transform against a round computed in the bench.
// The S-box is derived here from the GF(2^8) inverse and the affine map, and
// MixColumns uses a plain field multiply. Blocks and results move with random
// gaps and stalls on both channels, and each result is checked in order.
// ---------------------------------------------------------------------------
module tb;
	import aes_rt_pkg::*;

	localparam int IDLE_LIMIT  = 500;
	localparam int MAX_REPORTS = 10;
	localparam int RANDOM_BLOCKS = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	aes_rt_in_if  blk_if();
	aes_rt_out_if res_if();

	aes_round_transform DUT (
		.clk(clk),
		.arst_n(arst_n),
		.block(blk_if),
		.result(res_if)
	);

	logic [7:0] sub_table [256];
	logic [127:0] expected_rounds [$];
	int error_count = 0;
	int idle_cycles = 0;
	bit no_idle = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	// ---- round prediction ----

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		logic [7:0] p;
		int i;
		acc = 8'h00;
		p = a;
		for (i = 0; i < 8; i++) begin
			if (b[i])
				acc = acc ^ p;
			p = {p[6:0], 1'b0} ^ (p[7] ? 8'h1B : 8'h00);
		end
		return acc;
	endfunction

	function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
		return (x << n) | (x >> (8 - n));
	endfunction

	// S-box: multiplicative inverse (x^254, zero maps to zero), then affine map
	task automatic build_sub_table();
		logic [7:0] inv;
		logic [7:0] p;
		int v;
		int i;
		for (v = 0; v < 256; v++) begin
			inv = 8'h01;
			p = v[7:0];
			for (i = 0; i < 8; i++) begin
				if (i != 0)
					inv = gf_mul(inv, p);
				p = gf_mul(p, p);
			end
			if (v == 0)
				inv = 8'h00;
			sub_table[v] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3)
				^ rotl8(inv, 4) ^ 8'h63;
		end
	endtask

	function automatic logic [127:0] encrypt_round(input logic [127:0] st,
			input logic [127:0] key);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] m [16];
		logic [7:0] a0, a1, a2, a3;
		logic [127:0] res;
		int r, c, i;
		for (i = 0; i < 16; i++)
			s[i] = st[127 - 8*i -: 8];
		// row r rotates left by r
		for (r = 0; r < 4; r++)
			for (c = 0; c < 4; c++)
				t[4*r + c] = sub_table[s[4*r + ((c + r) % 4)]];
		// column c is bytes c, c+4, c+8, c+12
		for (c = 0; c < 4; c++) begin
			a0 = t[c];
			a1 = t[c + 4];
			a2 = t[c + 8];
			a3 = t[c + 12];
			m[c]      = gf_mul(a0, 8'h02) ^ gf_mul(a1, 8'h03) ^ a2 ^ a3;
			m[c + 4]  = a0 ^ gf_mul(a1, 8'h02) ^ gf_mul(a2, 8'h03) ^ a3;
			m[c + 8]  = a0 ^ a1 ^ gf_mul(a2, 8'h02) ^ gf_mul(a3, 8'h03);
			m[c + 12] = gf_mul(a0, 8'h03) ^ a1 ^ a2 ^ gf_mul(a3, 8'h02);
		end
		for (i = 0; i < 16; i++)
			res[127 - 8*i -: 8] = m[i] ^ key[127 - 8*i -: 8];
		return res;
	endfunction

	// ---- channel drivers ----

	function automatic int draw_wait();
		if (no_idle)
			return 0;
		return $urandom_range(0, 8);
	endfunction

	task automatic send_block(input logic [127:0] st, input logic [127:0] key);
		int gap;
		gap = draw_wait();
		repeat (gap) begin
			@(negedge clk);
			blk_if.valid <= 1'b0;
		end
		@(negedge clk);
		blk_if.valid        <= 1'b1;
		blk_if.block_hi     <= st[127:64];
		blk_if.block_lo     <= st[63:0];
		blk_if.round_key_hi <= key[127:64];
		blk_if.round_key_lo <= key[63:0];
		do @(posedge clk); while (!blk_if.ready);
		expected_rounds.push_back(encrypt_round(st, key));
	endtask

	initial begin
		int stall;
		res_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_wait();
			repeat (stall) begin
				@(negedge clk);
				res_if.ready <= 1'b0;
			end
			@(negedge clk);
			res_if.ready <= 1'b1;
			do @(posedge clk); while (!res_if.valid);
		end
	end

	// ---- result checking ----

	task automatic report_mismatch(input string what, input logic [63:0] exp_val,
			input logic [63:0] act_val);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("tb: mismatch on %s at %0t: expected %h, got %h",
				what, $realtime, exp_val, act_val);
	endtask

	always @(posedge clk) begin
		logic [127:0] exp_round;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (expected_rounds.size() == 0) begin
				report_mismatch("unexpected transaction out_hi", 64'h0, res_if.out_hi);
			end else begin
				exp_round = expected_rounds.pop_front();
				if (res_if.out_hi !== exp_round[127:64])
					report_mismatch("out_hi", exp_round[127:64], res_if.out_hi);
				if (res_if.out_lo !== exp_round[63:0])
					report_mismatch("out_lo", exp_round[63:0], res_if.out_lo);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((blk_if.valid && blk_if.ready) || (res_if.valid && res_if.ready))
				idle_cycles <= 0;
			else if (blk_if.valid || expected_rounds.size() != 0)
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: errors");
				$finish;
			end
		end
	end

	// ---- tests ----

	function automatic logic [63:0] rand_word();
		logic [63:0] w;
		int i;
		case ($urandom_range(0, 9))
			0: w = 64'h0;
			1: w = '1;
			2: begin
				for (i = 0; i < 8; i++)
					case ($urandom_range(0, 4))
						0: w[8*i +: 8] = 8'h00;
						1: w[8*i +: 8] = 8'hFF;
						2: w[8*i +: 8] = 8'h80;
						3: w[8*i +: 8] = 8'h7F;
						default: w[8*i +: 8] = 8'h01;
					endcase
			end
			default: w = {$urandom(), $urandom()};
		endcase
		return w;
	endfunction

	task automatic test_extremes();
		no_idle = 1'b1;
		send_block('0, '0);
		send_block('1, '1);
		send_block('0, '1);
		send_block('1, '0);
		no_idle = 1'b0;
		send_block({16{8'h55}}, {16{8'hAA}});
		send_block({16{8'hAA}}, {16{8'h55}});
	endtask

	// one marked byte per block, in each of the 16 positions in turn, shows where each byte lands after the shift
	task automatic test_byte_lanes();
		logic [127:0] st;
		int i;
		for (i = 0; i < 16; i++) begin
			st = '0;
			st[127 - 8*i -: 8] = 8'h80 + i[7:0];
			send_block(st, {$urandom(), $urandom(), $urandom(), $urandom()});
		end
	endtask

	task automatic test_random_blocks();
		int n;
		for (n = 0; n < RANDOM_BLOCKS; n++) begin
			// occasional flips give back-to-back stretches with no gaps
			if ($urandom_range(0, 49) == 0)
				no_idle = ~no_idle;
			send_block({rand_word(), rand_word()}, {rand_word(), rand_word()});
		end
		no_idle = 1'b0;
	endtask

	initial begin
		blk_if.valid        = 1'b0;
		blk_if.block_hi     = '0;
		blk_if.block_lo     = '0;
		blk_if.round_key_hi = '0;
		blk_if.round_key_lo = '0;
		build_sub_table();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_extremes();
		test_byte_lanes();
		test_random_blocks();

		@(negedge clk);
		blk_if.valid <= 1'b0;
		while (expected_rounds.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/aes_rt_pkg.sv
hdl/aes_rt_in_if.sv
hdl/aes_rt_out_if.sv
hdl/aes_rt_lane.sv
hdl/aes_rt_merge.sv
hdl/aes_round_transform.sv
test/tb.sv
